// ===== rtl/ntab_pkg.sv =====
// Package for the neighbor table: entry, request and result types, opcodes,
// field offsets of the stream words and fixed constants. No dependencies.
package ntab_pkg;

    localparam logic [1:0] OP_NOTE   = 2'd0;
    localparam logic [1:0] OP_EXPIRE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] AGE_RESET = 32'd6000;

    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_USER_W = 1;
    localparam int CFG_W      = 32;

    localparam int IN_ID_LSB   = 0;
    localparam int IN_PAY_LSB  = 24;
    localparam int IN_NOW_LSB  = 88;
    localparam int IN_IDX_LSB  = 120;
    localparam int IN_USED_W   = 125;

    localparam int OUT_ID_LSB   = 0;
    localparam int OUT_PAY_LSB  = 24;
    localparam int OUT_TIME_LSB = 88;
    localparam int OUT_SLOT_LSB = 120;
    localparam int OUT_REPL_BIT = 125;
    localparam int OUT_CNT_LSB  = 126;
    localparam int OUT_USED_W   = 132;

    typedef struct packed {
        logic [31:0] last_seen;
        logic [63:0] payload;
        logic [23:0] id;
    } entry_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] node_id;
        logic [63:0] payload;
        logic [31:0] now_ms;
        logic [4:0]  read_index;
    } req_t;

    typedef struct packed {
        logic        entry_valid;
        logic [23:0] entry_id;
        logic [63:0] entry_payload;
        logic [31:0] entry_last_seen;
        logic [4:0]  slot_used;
        logic        replaced_oldest;
        logic [5:0]  entry_count;
    } result_t;

endpackage

// ===== rtl/ntab_mem.sv =====
// Entry store of the neighbor table: one write port, one read port with a
// registered read. Depends on ntab_pkg for the entry type.
module ntab_mem #(
    parameter int ENTRIES = 32,
    parameter int IW      = 5
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  ntab_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_addr,
    output ntab_pkg::entry_t rd_data
);

    ntab_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ntab_ctrl.sv =====
// Sequencer of the neighbor table: lookup, oldest search, expire compaction
// and read over the entry store, plus the result register.
// Depends on ntab_pkg; drives the ports of ntab_mem.
module ntab_ctrl #(
    parameter int ENTRIES = 32,
    parameter int IW      = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ntab_pkg::req_t    req,
    input  logic [31:0]       max_age,
    output logic              res_valid,
    input  logic              res_ready,
    output ntab_pkg::result_t res,
    output logic              mem_rd_en,
    output logic [IW-1:0]     mem_rd_addr,
    input  ntab_pkg::entry_t  mem_rd_data,
    output logic              mem_wr_en,
    output logic [IW-1:0]     mem_wr_addr,
    output ntab_pkg::entry_t  mem_wr_data
);

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EXP  = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     keep_reg, keep_next;
    logic              rv_reg, rv_next;
    logic [IW-1:0]     ri_reg, ri_next;
    logic              out_valid_reg, out_valid_next;

    logic [1:0]        op_reg, op_next;
    logic [23:0]       id_reg, id_next;
    logic [63:0]       pay_reg, pay_next;
    logic [31:0]       now_reg, now_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [31:0]       min_reg, min_next;
    logic              ev_reg, ev_next;
    logic              rvalid_reg, rvalid_next;
    ntab_pkg::entry_t  rentry_reg, rentry_next;
    ntab_pkg::result_t out_reg, out_next;

    logic              last;
    logic [CMPW-1:0]   idx_w;
    logic [CMPW-1:0]   cnt_w;
    logic [31:0]       age;
    logic              kept;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign last  = rv_reg && ((CW'(ri_reg) + CW'(1)) == count_reg);
    assign idx_w = CMPW'(req.read_index);
    assign cnt_w = CMPW'(count_reg);
    assign age   = now_reg - mem_rd_data.last_seen;
    assign kept  = (age <= max_age);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        pay_next       = pay_reg;
        now_next       = now_reg;
        slot_next      = slot_reg;
        min_next       = min_reg;
        ev_next        = ev_reg;
        rvalid_next    = rvalid_reg;
        rentry_next    = rentry_reg;
        out_next       = out_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = iss_reg[IW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_reg;
        mem_wr_data.id        = id_reg;
        mem_wr_data.payload   = pay_reg;
        mem_wr_data.last_seen = now_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    id_next     = req.node_id;
                    pay_next    = req.payload;
                    now_next    = req.now_ms;
                    iss_next    = '0;
                    keep_next   = '0;
                    min_next    = ntab_pkg::TIME_MAX;
                    slot_next   = '0;
                    ev_next     = 1'b0;
                    rvalid_next = 1'b0;
                    rentry_next = '0;
                    unique case (req.opcode)
                        ntab_pkg::OP_NOTE:
                        begin
                            if (count_reg == '0)
                            begin
                                count_next = CW'(1);
                                state_next = S_WR;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ntab_pkg::OP_EXPIRE:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_EXP;
                        end
                        ntab_pkg::OP_READ:
                        begin
                            if (idx_w < cnt_w)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = IW'(idx_w);
                                state_next  = S_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (iss_reg < count_reg)
                begin
                    mem_rd_en = 1'b1;
                    iss_next  = iss_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    if (mem_rd_data.id == id_reg)
                    begin
                        slot_next  = ri_reg;
                        state_next = S_WR;
                    end
                    else
                    begin
                        if (mem_rd_data.last_seen < min_reg)
                        begin
                            min_next  = mem_rd_data.last_seen;
                            slot_next = ri_reg;
                        end
                        if (last)
                        begin
                            if (count_reg < CW'(ENTRIES))
                            begin
                                slot_next  = count_reg[IW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ev_next = 1'b1;
                            end
                            state_next = S_WR;
                        end
                    end
                end
            end
            S_EXP:
            begin
                if (iss_reg < count_reg)
                begin
                    mem_rd_en = 1'b1;
                    iss_next  = iss_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    if (kept)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = keep_reg[IW-1:0];
                        mem_wr_data = mem_rd_data;
                        keep_next   = keep_reg + CW'(1);
                    end
                    if (last)
                    begin
                        count_next = keep_reg + CW'(kept);
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                rentry_next = mem_rd_data;
                rvalid_next = 1'b1;
                state_next  = S_DONE;
            end
            S_WR:
            begin
                mem_wr_en  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_next.entry_valid     = rvalid_reg;
                    out_next.entry_id        = rentry_reg.id;
                    out_next.entry_payload   = rentry_reg.payload;
                    out_next.entry_last_seen = rentry_reg.last_seen;
                    out_next.slot_used       = (op_reg == ntab_pkg::OP_NOTE) ?
                                               5'(slot_reg) : 5'd0;
                    out_next.replaced_oldest = ev_reg;
                    out_next.entry_count     = 6'(count_reg);
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rv_next = mem_rd_en;
    assign ri_next = mem_rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            keep_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            keep_reg      <= keep_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ri_reg     <= ri_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        pay_reg    <= pay_next;
        now_reg    <= now_next;
        slot_reg   <= slot_next;
        min_reg    <= min_next;
        ev_reg     <= ev_next;
        rvalid_reg <= rvalid_next;
        rentry_reg <= rentry_next;
        out_reg    <= out_next;
    end

endmodule

// ===== rtl/neighbor_table_with_aging_top.sv =====
// Top level of the neighbor table with aging: stream ports, the max_age_ms
// register and the wiring of ntab_ctrl and ntab_mem. Depends on ntab_pkg.
//
// Requests enter on the s_ group; opcode travels in s_tuser and selects note,
// expire or read. Each request yields exactly one result on the m_ group.
// The table holds up to ENTRIES peers in one synchronous memory.
// A note reads each stored entry and then does one write; a hit ends the
// lookup early, and a note on an empty table goes straight to the write.
// An expire reads each stored entry once. The lookup and compaction walk
// the single read port of the entry memory one entry per cycle. One request
// is in work at a time; the next one is taken while a finished result waits
// in the output register. A stalled receiver holds that result, and the
// block then stops taking requests once the following result is also
// finished. max_age_ms is written on the cfg_ channel, always ready; the
// user must write it only while idle, which the block itself does not
// enforce. Reset empties the table (count zero) and sets max_age_ms to
// 6000; no clearing pass runs, so requests are taken right after reset.
module neighbor_table_with_aging_top #(
    parameter int ENTRIES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node_id[23:0], payload[87:24], now_ms[119:88], read_index[124:120]
    input  logic [ntab_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode[1:0]
    input  logic [ntab_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // entry_id[23:0], entry_payload[87:24], entry_last_seen[119:88],
    // slot_used[124:120], replaced_oldest[125], entry_count[131:126]
    output logic [ntab_pkg::OUT_DATA_W-1:0]     m_tdata,
    // entry_valid[0]
    output logic [ntab_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ntab_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IW = $clog2(ENTRIES);

    logic [31:0]       max_age_reg;
    ntab_pkg::req_t    req;
    ntab_pkg::result_t res;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    ntab_pkg::entry_t  mem_rd_data;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    ntab_pkg::entry_t  mem_wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= ntab_pkg::AGE_RESET;
        end
        else if (cfg_valid)
        begin
            max_age_reg <= cfg_data;
        end
    end

    assign req.opcode     = s_tuser[1:0];
    assign req.node_id    = s_tdata[ntab_pkg::IN_PAY_LSB-1:ntab_pkg::IN_ID_LSB];
    assign req.payload    = s_tdata[ntab_pkg::IN_NOW_LSB-1:ntab_pkg::IN_PAY_LSB];
    assign req.now_ms     = s_tdata[ntab_pkg::IN_IDX_LSB-1:ntab_pkg::IN_NOW_LSB];
    assign req.read_index = s_tdata[ntab_pkg::IN_USED_W-1:ntab_pkg::IN_IDX_LSB];

    assign m_tuser = res.entry_valid;
    assign m_tdata = {
        {(ntab_pkg::OUT_DATA_W - ntab_pkg::OUT_USED_W){1'b0}},
        res.entry_count,
        res.replaced_oldest,
        res.slot_used,
        res.entry_last_seen,
        res.entry_payload,
        res.entry_id
    };

    ntab_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .max_age     (max_age_reg),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    ntab_mem #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/ntab_checker.sv =====
// Port-level checks of the neighbor table and the bind that attaches them
// to neighbor_table_with_aging_top. Depends on ntab_pkg for field offsets.
module ntab_checker #(
    parameter int ENTRIES = 32
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ntab_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [ntab_pkg::OUT_USER_W-1:0] m_tuser
);

    logic [5:0] cnt;
    logic [4:0] slot;
    logic       repl;

    assign cnt  = m_tdata[ntab_pkg::OUT_CNT_LSB +: 6];
    assign slot = m_tdata[ntab_pkg::OUT_SLOT_LSB +: 5];
    assign repl = m_tdata[ntab_pkg::OUT_REPL_BIT];

    // A result that carries an entry comes from a read and writes no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> slot == 5'd0 && !repl)
        else $error("read result carries note fields");

    // Eviction happens only on a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && repl |-> cnt == 6'(ENTRIES))
        else $error("eviction reported on a table that is not full");

    // The reported count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(cnt) <= ENTRIES)
        else $error("entry count beyond table depth");

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind neighbor_table_with_aging_top ntab_checker #(.ENTRIES(ENTRIES)) u_ntab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
